/* src/request_tag_allocator_assert.svh */
// Assertion macros for the request tag allocator.
// Included by rta_datapath, which checks its own logic; needs clk_i and rst_ni in scope.
`ifndef REQUEST_TAG_ALLOCATOR_ASSERT_SVH
`define REQUEST_TAG_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define RTA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("request_tag_allocator: assertion failed");

// Next-cycle implication, disabled while reset is active.
`define RTA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("request_tag_allocator: assertion failed");

`endif

/* src/rta_pkg.sv */
// Shared types and constants of the request tag allocator.
// No dependencies; imported by every module of the block.
package rta_pkg;

  // Pool size and derived widths.
  localparam int NUM_TAGS = 32;
  localparam int TAG_W    = $clog2(NUM_TAGS);
  localparam int CNT_W    = $clog2(NUM_TAGS + 1);
  localparam int ID_W     = 32;
  localparam int GRANT_W  = 5;
  localparam int LIVE_W   = 6;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_RELEASE  = 2'd1,
    OP_RESPONSE = 2'd2,
    OP_QUERY    = 2'd3
  } op_e;

  // Status codes of a result word.
  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_NOT_IN_USE = 2'd2,
    STAT_RANGE      = 2'd3
  } status_e;

  // Input word.
  typedef struct packed {
    op_e              op;
    logic [ID_W-1:0]  tag_id;
  } req_t;

  // Result word.
  typedef struct packed {
    status_e             status;
    logic [GRANT_W-1:0]  granted_tag;
    logic                tag_busy;
    logic                tag_ready;
    logic [LIVE_W-1:0]   live_count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
  } dp_cmd_t;

endpackage

/* src/rta_ctrl.sv */
// Controller of the request tag allocator: sequences capture and execute steps.
// Depends on rta_pkg.
module rta_ctrl
  import rta_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  output logic    done_o,
  output dp_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic done_q, done_d;

  // Next state: an accepted word moves from idle to execute, and execute always returns to idle.
  always_comb begin
    state_d     = state_q;
    done_d      = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        done_d     = 1'b1;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and result strobe registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q == ST_EXEC);
  assign done_o = done_q;

endmodule

/* src/rta_datapath.sv */
// Datapath of the request tag allocator: tag flags, live count, probe pointer,
// round-robin free search and result register. Depends on rta_pkg and the assert header.
`include "request_tag_allocator_assert.svh"

module rta_datapath
  import rta_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  dp_cmd_t cmd_i,
  input  req_t    req_i,
  output rsp_t    rsp_o
);

  logic [NUM_TAGS-1:0] busy_q, busy_d;
  logic [NUM_TAGS-1:0] ready_q, ready_d;
  logic [TAG_W-1:0]    probe_q, probe_d;
  logic [CNT_W-1:0]    count_q, count_d;
  op_e                 op_q;
  logic [ID_W-1:0]     tag_id_q;
  rsp_t                rsp_q, rsp_d;

  logic [2*NUM_TAGS-1:0] free_dbl;
  logic [NUM_TAGS-1:0]   window;
  logic [TAG_W-1:0]      offset;
  logic [TAG_W:0]        grant_sum;
  logic [TAG_W-1:0]      grant;
  logic [TAG_W:0]        probe_nxt;
  logic                  any_free;
  logic                  full;
  logic                  in_range;
  logic [TAG_W-1:0]      idx;

  // Free flags rotated so that the probe position sits at bit zero.
  assign free_dbl = {~busy_q, ~busy_q} >> probe_q;
  assign window   = free_dbl[NUM_TAGS-1:0];
  assign any_free = |window;

  // Lowest set bit of the rotated window is the nearest free tag.
  always_comb begin
    offset = '0;
    for (int i = NUM_TAGS - 1; i >= 0; i--) begin
      if (window[i]) begin
        offset = TAG_W'(i);
      end
    end
  end

  // Undo the rotation and derive the probe for the following allocate.
  always_comb begin
    grant_sum = {1'b0, probe_q} + {1'b0, offset};
    if (grant_sum >= (TAG_W+1)'(NUM_TAGS)) begin
      grant_sum = grant_sum - (TAG_W+1)'(NUM_TAGS);
    end
    grant     = grant_sum[TAG_W-1:0];
    probe_nxt = {1'b0, grant} + (TAG_W+1)'(1);
    if (probe_nxt >= (TAG_W+1)'(NUM_TAGS)) begin
      probe_nxt = '0;
    end
  end

  assign full     = (count_q >= CNT_W'(NUM_TAGS)) || !any_free;
  assign in_range = (tag_id_q < ID_W'(NUM_TAGS));
  assign idx      = tag_id_q[TAG_W-1:0];

  // Operation decode: state update and result word.
  always_comb begin
    busy_d  = busy_q;
    ready_d = ready_q;
    probe_d = probe_q;
    count_d = count_q;
    rsp_d   = rsp_q;
    if (cmd_i.exec) begin
      rsp_d.status      = STAT_OK;
      rsp_d.granted_tag = '0;
      rsp_d.tag_busy    = 1'b0;
      rsp_d.tag_ready   = 1'b0;
      if (op_q == OP_ALLOC) begin
        if (full) begin
          rsp_d.status = STAT_FULL;
        end else begin
          busy_d[grant]     = 1'b1;
          ready_d[grant]    = 1'b0;
          count_d           = count_q + CNT_W'(1);
          probe_d           = probe_nxt[TAG_W-1:0];
          rsp_d.granted_tag = GRANT_W'(grant);
          rsp_d.tag_busy    = 1'b1;
        end
      end else if (!in_range) begin
        rsp_d.status = STAT_RANGE;
      end else begin
        rsp_d.granted_tag = GRANT_W'(idx);
        if (op_q == OP_QUERY) begin
          rsp_d.tag_busy  = busy_q[idx];
          rsp_d.tag_ready = ready_q[idx];
        end else if (!busy_q[idx]) begin
          rsp_d.status = STAT_NOT_IN_USE;
        end else if (op_q == OP_RELEASE) begin
          busy_d[idx]  = 1'b0;
          ready_d[idx] = 1'b0;
          if (count_q != '0) begin
            count_d = count_q - CNT_W'(1);
          end
        end else begin
          ready_d[idx]    = 1'b1;
          rsp_d.tag_busy  = 1'b1;
          rsp_d.tag_ready = 1'b1;
        end
      end
      rsp_d.live_count = LIVE_W'(count_d);
    end
  end

  // Pool state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= '0;
      ready_q <= '0;
      probe_q <= '0;
      count_q <= '0;
    end else begin
      busy_q  <= busy_d;
      ready_q <= ready_d;
      probe_q <= probe_d;
      count_q <= count_d;
    end
  end

  // Captured request word and result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= req_i.op;
      tag_id_q <= req_i.tag_id;
    end
    rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

  // The live count always matches the number of busy flags.
  `RTA_ASSERT_IMPL(a_count_matches, 1'b1, count_q == CNT_W'($countones(busy_q)))
  // A tag is never ready without being busy.
  `RTA_ASSERT_IMPL(a_ready_needs_busy, 1'b1, (ready_q & ~busy_q) == '0)
  // The probe pointer stays inside the pool.
  `RTA_ASSERT_IMPL(a_probe_in_pool, 1'b1, probe_q <= TAG_W'(NUM_TAGS - 1))
  // A granted tag is busy and not ready right after the allocate.
  `RTA_ASSERT_NEXT(a_grant_marked, cmd_i.exec && op_q == OP_ALLOC && !full,
                   busy_q[$past(grant)] && !ready_q[$past(grant)])

endmodule

/* src/request_tag_allocator.sv */
// Top level of the request tag allocator.
// Depends on rta_pkg, rta_ctrl and rta_datapath.
//
// Usage: a request word (op, tag_id) is taken at a rising edge where start is
// high and busy is low. Allocate grants the nearest free tag at or after the
// round-robin probe pointer; release frees a tag, response marks a busy tag
// ready and query reports a tag's flags. Every request yields exactly one
// result word on rsp_o, shown for a single cycle with done_o high.
// Sequence: the accepting edge captures the word and enters execute, in which the
// rotated free-flag search and the flag update complete; the result and done_o
// are registered at the end of execute and shown from those registers. busy is
// high for one cycle, so a new word cannot be accepted while the previous one is
// in execute. A new word may be accepted at the edge that takes the previous
// result, since the result sits in its own register.
// The receiver cannot stall: a result is taken in the cycle it is shown.
// Reset clears all busy and ready flags, the live count and the probe pointer
// at once; the block accepts requests as soon as reset is released.
module request_tag_allocator
  import rta_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  dp_cmd_t cmd;

  // Sequencing of capture and execute.
  rta_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // Tag pool and result register.
  rta_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule
